@@ hdl/rbst_pkg.sv @@
// rbst_pkg: shared types and constants for the ray versus box slab pipeline
// used by ray_box_slab_trace and its fraction divider rbst_div
package rbst_pkg;

  // quotient bits below the saturation cap, and fraction bits of Q16.16
  localparam int QBits     = 31;
  localparam int FracBits  = 16;
  // divider depth: its input register, one step register per quotient bit, and the quotient register
  localparam int DivLat    = QBits + 2;
  localparam int NumFaces  = 6;

  localparam logic [2:0]         FACE_NONE = 3'd6;
  localparam logic signed [31:0] FRAC_ONE  = 32'sh0001_0000;
  localparam logic signed [31:0] FRAC_MAX  = 32'sh7FFF_FFFF;

  // what a face does to the ray
  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,
    KIND_FRONT = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_EXIT  = 2'd3
  } kind_e;

endpackage

@@ hdl/rbst_div.sv @@
// rbst_div: pipelined Q16.16 fraction divider, one quotient bit per stage
// depends on rbst_pkg; result is the signed, saturated 32-bit quotient
module rbst_div #(
  parameter int MW = 35
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [MW-1:0]            num_i,
  input  logic [MW-1:0]            den_i,
  input  logic                     neg_i,
  output logic signed [31:0]       quo_o
);

  localparam int NS = rbst_pkg::QBits;

  logic [MW-1:0]          r_q   [NS+1];
  logic [MW-1:0]          b_q   [NS+1];
  logic [14:0]            lo_q  [NS+1];
  logic [NS-1:0]          q_q   [NS+1];
  logic                   cap_q [NS+1];
  logic                   neg_q [NS+1];
  logic signed [31:0]     quo_q;

  logic                   cap_d;
  logic [31:0]            mag_d;
  logic signed [31:0]     quo_d;

  // quotient reaches 2^31 when num >= den * 2^15
  assign cap_d = {15'd0, num_i} >= {den_i, 15'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= num_i >> 15;
      b_q[0]   <= den_i;
      lo_q[0]  <= num_i[14:0];
      q_q[0]   <= '0;
      cap_q[0] <= cap_d;
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_step
    localparam int BI = NS - 1 - k;
    logic          nb;
    logic [MW:0]   rext;
    logic [MW+1:0] dif;

    if (BI >= rbst_pkg::FracBits) begin : g_lo
      assign nb = lo_q[k][BI-rbst_pkg::FracBits];
    end else begin : g_zero
      assign nb = 1'b0;
    end

    assign rext = {r_q[k], nb};
    assign dif  = {1'b0, rext} - {2'b00, b_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= dif[MW+1] ? rext[MW-1:0] : dif[MW-1:0];
        q_q[k+1]   <= {q_q[k][NS-2:0], ~dif[MW+1]};
        b_q[k+1]   <= b_q[k];
        lo_q[k+1]  <= lo_q[k];
        cap_q[k+1] <= cap_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  assign mag_d = cap_q[NS] ? 32'h8000_0000 : {1'b0, q_q[NS]};
  assign quo_d = neg_q[NS] ? -$signed(mag_d)
               : (cap_q[NS] ? rbst_pkg::FRAC_MAX : $signed(mag_d));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

@@ hdl/ray_box_slab_trace.sv @@
// ray_box_slab_trace: Q16.16 ray versus axis-aligned box slab test
// depends on rbst_pkg and rbst_div (six fraction dividers, one per face)
// beats pass stage 1, stage 2, the divider pipelines (most of the depth), combine, result register
// one beat per cycle sustained while the result is taken; the whole pipe stalls as one
// reset (async, active low) clears valid bits and the tolerance register only
module ray_box_slab_trace #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [30:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_z_i,
  input  logic signed [COORD_WIDTH-1:0] delta_x_i,
  input  logic signed [COORD_WIDTH-1:0] delta_y_i,
  input  logic signed [COORD_WIDTH-1:0] delta_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_min_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_max_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o,
  output logic                          start_solid_o,
  output logic signed [31:0]            t_enter_o,
  output logic signed [31:0]            t_exit_o,
  output logic [2:0]                    hit_side_o
);

  localparam int W  = COORD_WIDTH;
  // internal signed width: holds d1 +/- tolerance and d1 - d2 without wrap
  localparam int SW = ((W > 31) ? W : 31) + 3;
  // helper width for the 64-bit saturation check
  localparam int XW = (SW > 64) ? SW : 65;
  localparam int NF = rbst_pkg::NumFaces;
  localparam int DL = rbst_pkg::DivLat;

  // clamp to the signed 64-bit range, only bites for very wide coordinates
  function automatic logic signed [SW-1:0] sat64(input logic signed [SW-1:0] v);
    logic signed [XW-1:0] ve;
    logic                 ovf;
    ve  = XW'(v);
    ovf = !((&ve[XW-1:63]) || !(|ve[XW-1:63]));
    if (ovf) begin
      ve = {{(XW-63){ve[XW-1]}}, {63{~ve[XW-1]}}};
    end
    return ve[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sx(input logic signed [W-1:0] v);
    return {{(SW-W){v[W-1]}}, v};
  endfunction

  // global stall: the whole pipe moves when the result register can take a beat
  logic en;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  // tolerance register
  logic [30:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i) begin
      tol_q <= cfg_data_i;
    end
  end

  logic signed [SW-1:0] tol_s;
  assign tol_s = {{(SW-31){1'b0}}, tol_q};

  // per-axis views of the input beat
  logic signed [W-1:0] st [3];
  logic signed [W-1:0] dl [3];
  logic signed [W-1:0] bn [3];
  logic signed [W-1:0] bx [3];
  assign st = '{start_x_i, start_y_i, start_z_i};
  assign dl = '{delta_x_i, delta_y_i, delta_z_i};
  assign bn = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign bx = '{box_max_x_i, box_max_y_i, box_max_z_i};

  // stage 1: start and end distances in front of each face
  logic signed [SW-1:0] d1_d [NF];
  logic signed [SW-1:0] d2_d [NF];
  logic signed [SW-1:0] d1_q [NF];
  logic signed [SW-1:0] d2_q [NF];
  logic                 s1_v_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      // min faces first
      d1_d[a]   = sat64(sx(bn[a]) - sx(st[a]));
      d2_d[a]   = sat64(d1_d[a] - sx(dl[a]));
      // then max faces
      d1_d[a+3] = sat64(sx(st[a]) - sx(bx[a]));
      d2_d[a+3] = sat64(d1_d[a+3] + sx(dl[a]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q <= d1_d;
      d2_q <= d2_d;
    end
  end

  // stage 2: classify faces, build numerator and denominator magnitudes
  rbst_pkg::kind_e      kind_d [NF];
  logic [SW-1:0]        nmag_d [NF];
  logic [SW-1:0]        dmag_d [NF];
  logic                 neg_d  [NF];
  rbst_pkg::kind_e      kind_q [NF];
  logic [SW-1:0]        nmag_q [NF];
  logic [SW-1:0]        dmag_q [NF];
  logic                 neg_q  [NF];
  logic                 s2_v_q;

  always_comb begin
    logic                 p1;
    logic                 p2;
    logic signed [SW-1:0] n;
    logic signed [SW-1:0] dn;
    for (int f = 0; f < NF; f++) begin
      p1 = !d1_q[f][SW-1] && (|d1_q[f]);
      p2 = !d2_q[f][SW-1] && (|d2_q[f]);
      dn = sat64(d1_q[f] - d2_q[f]);
      if (p1) begin
        // entry crossing, slack pulls the entry point earlier, floored at zero
        n = sat64(d1_q[f] - tol_s);
        if (n[SW-1]) begin
          n = '0;
        end
      end else begin
        n = sat64(d1_q[f] + tol_s);
      end
      if (p1 && p2) begin
        kind_d[f] = rbst_pkg::KIND_FRONT;
      end else if (!p1 && !p2) begin
        kind_d[f] = rbst_pkg::KIND_SKIP;
      end else if (p1) begin
        kind_d[f] = rbst_pkg::KIND_ENTRY;
      end else begin
        kind_d[f] = rbst_pkg::KIND_EXIT;
      end
      nmag_d[f] = n[SW-1] ? SW'(-n) : SW'(n);
      dmag_d[f] = dn[SW-1] ? SW'(-dn) : SW'(dn);
      neg_d[f]  = n[SW-1] ^ dn[SW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q <= kind_d;
      nmag_q <= nmag_d;
      dmag_q <= dmag_d;
      neg_q  <= neg_d;
    end
  end

  // divider stages: six fraction dividers, face kinds ride alongside
  logic signed [31:0] frac [NF];
  for (genvar f = 0; f < NF; f++) begin : g_div
    rbst_div #(
      .MW (SW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (nmag_q[f]),
      .den_i (dmag_q[f]),
      .neg_i (neg_q[f]),
      .quo_o (frac[f])
    );
  end

  rbst_pkg::kind_e kp_q [DL][NF];
  logic [DL-1:0]   kv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      kp_q[0] <= kind_q;
      for (int k = 1; k < DL; k++) begin
        kp_q[k] <= kp_q[k-1];
      end
    end
  end

  // combine stage: walk the faces in order, stop at a face wholly in front
  logic signed [31:0] t1_d;
  logic signed [31:0] t2_d;
  logic [2:0]         side_d;
  logic               solid_d;
  logic               stop_d;
  logic signed [31:0] t1_q;
  logic signed [31:0] t2_q;
  logic [2:0]         side_q;
  logic               solid_q;
  logic               stop_q;
  logic               cb_v_q;

  always_comb begin
    t1_d    = -rbst_pkg::FRAC_ONE;
    t2_d    = rbst_pkg::FRAC_ONE;
    side_d  = rbst_pkg::FACE_NONE;
    solid_d = 1'b1;
    stop_d  = 1'b0;
    for (int f = 0; f < NF; f++) begin
      if (!stop_d) begin
        case (kp_q[DL-1][f])
          rbst_pkg::KIND_FRONT: begin
            stop_d = 1'b1;
          end
          rbst_pkg::KIND_ENTRY: begin
            solid_d = 1'b0;
            if (frac[f] > t1_d) begin
              t1_d   = frac[f];
              side_d = 3'(f);
            end
          end
          rbst_pkg::KIND_EXIT: begin
            if (frac[f] < t2_d) begin
              t2_d = frac[f];
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q    <= t1_d;
      t2_q    <= t2_d;
      side_q  <= side_d;
      solid_q <= solid_d;
      stop_q  <= stop_d;
    end
  end

  // result register
  logic signed [31:0] te_q;
  logic signed [31:0] tx_q;
  logic [2:0]         hs_q;
  logic               hit_q;
  logic               sol_q;
  logic               out_v_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      te_q  <= t1_q;
      tx_q  <= t2_q;
      hs_q  <= side_q;
      sol_q <= solid_q && !stop_q;
      hit_q <= !stop_q && (solid_q || ((t1_q < t2_q) && !t1_q[31]));
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      kv_q    <= '0;
      cb_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_valid_i;
      s2_v_q  <= s1_v_q;
      kv_q    <= {kv_q[DL-2:0], s2_v_q};
      cb_v_q  <= kv_q[DL-1];
      out_v_q <= cb_v_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign hit_o         = hit_q;
  assign start_solid_o = sol_q;
  assign t_enter_o     = te_q;
  assign t_exit_o      = tx_q;
  assign hit_side_o    = hs_q;

endmodule

@@ tb/sv/ray_box_slab_trace_tb.sv @@
// ray_box_slab_trace_tb: self-checking bench for the q16.16 ray versus box slab pipeline
// depends on rbst_pkg and ray_box_slab_trace; a small class predicts and scores results
module ray_box_slab_trace_tb;

  typedef struct {
    logic signed [31:0] start [3];
    logic signed [31:0] delta [3];
    logic signed [31:0] bmin [3];
    logic signed [31:0] bmax [3];
  } ray_box_t;

  typedef struct {
    logic               hit;
    logic               solid;
    logic signed [31:0] t_enter;
    logic signed [31:0] t_exit;
    logic [2:0]         side;
  } slab_res_t;

  // 64-bit saturating helpers
  function automatic longint sat_add64(longint a, longint b);
    longint s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? 64'sh8000_0000_0000_0000
                                                       : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  function automatic longint sat_sub64(longint a, longint b);
    longint s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? 64'sh8000_0000_0000_0000
                                                       : 64'sh7FFF_FFFF_FFFF_FFFF;
    return s;
  endfunction

  // signed q16.16 quotient, truncated, capped at 2^31 before sign
  function automatic longint frac_quot(longint num, longint den);
    logic [63:0]  n, d;
    logic [127:0] q;
    n = num < 0 ? 64'(-num) : 64'(num);
    d = den < 0 ? 64'(-den) : 64'(den);
    q = {n, 16'b0} / {64'b0, d};
    if (q > 128'h8000_0000) q = 128'h8000_0000;
    if ((num < 0) != (den < 0)) return -longint'(q);
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return longint'(q);
  endfunction

  class slab_scoreboard;
    logic [30:0] tolerance;
    slab_res_t   pending[$];
    int          errors;
    int          checked;

    function void note_ray(ray_box_t r);
      longint    t1, t2, d1, d2, f, tol, nm;
      slab_res_t e;
      int        a;
      bit        stop;
      t1 = -65536; t2 = 65536; tol = tolerance;
      e.solid = 1; e.side = rbst_pkg::FACE_NONE; e.hit = 0;
      stop = 0;
      for (int i = 0; i < rbst_pkg::NumFaces; i++) begin
        a = i % 3;
        if (i >= 3) begin
          d1 = sat_sub64(r.start[a], r.bmax[a]);
          d2 = sat_add64(d1, r.delta[a]);
        end else begin
          d1 = sat_sub64(r.bmin[a], r.start[a]);
          d2 = sat_sub64(d1, r.delta[a]);
        end
        // face wholly in front: early miss
        if (d1 > 0 && d2 > 0) begin
          e.solid = 0;
          stop = 1;
          break;
        end
        if (d1 <= 0 && d2 <= 0) continue;
        if (d1 > 0) e.solid = 0;
        if (d1 > d2) begin
          nm = sat_sub64(d1, tol);
          if (nm < 0) nm = 0;
          f = frac_quot(nm, sat_sub64(d1, d2));
          if (f > t1) begin
            t1 = f;
            e.side = 3'(i);
          end
        end else begin
          f = frac_quot(sat_add64(d1, tol), sat_sub64(d1, d2));
          if (f < t2) t2 = f;
        end
      end
      if (!stop) e.hit = e.solid || (t1 < t2 && t1 >= 0);
      e.t_enter = 32'(t1);
      e.t_exit  = 32'(t2);
      pending = {pending, e};
    endfunction

    function void check_result(slab_res_t got);
      slab_res_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.hit !== e.hit) begin
        $error("hit: expected %0d actual %0d", e.hit, got.hit); errors++;
      end
      if (got.solid !== e.solid) begin
        $error("start_solid: expected %0d actual %0d", e.solid, got.solid); errors++;
      end
      if (got.t_enter !== e.t_enter) begin
        $error("t_enter: expected %0h actual %0h", e.t_enter, got.t_enter); errors++;
      end
      if (got.t_exit !== e.t_exit) begin
        $error("t_exit: expected %0h actual %0h", e.t_exit, got.t_exit); errors++;
      end
      if (got.side !== e.side) begin
        $error("hit_side: expected %0d actual %0d", e.side, got.side); errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_valid_i = 0;
  logic               cfg_ready_o;
  logic [30:0]        cfg_data_i = '0;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  logic signed [31:0] start_x_i = 0, start_y_i = 0, start_z_i = 0;
  logic signed [31:0] delta_x_i = 0, delta_y_i = 0, delta_z_i = 0;
  logic signed [31:0] box_min_x_i = 0, box_min_y_i = 0, box_min_z_i = 0;
  logic signed [31:0] box_max_x_i = 0, box_max_y_i = 0, box_max_z_i = 0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  logic               hit_o, start_solid_o;
  logic signed [31:0] t_enter_o, t_exit_o;
  logic [2:0]         hit_side_o;

  ray_box_slab_trace #(.COORD_WIDTH(32)) dut (.*);

  always #1 clk_i = ~clk_i;

  slab_scoreboard sb = new();

  // idling: percentage of cycles each side sits out
  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_off;
  int  hold_cycles;
  longint cycle_count;
  int  rays_sent;
  int  cfg_writes;
  localparam longint CycleLimit = 2_000_000;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("ray_box_slab_trace_tb: done, errors");
      $finish;
    end
  end

  // result side: sample at rising edge, change ready at falling edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result('{hit_o, start_solid_o, t_enter_o, t_exit_o, hit_side_o});
  end

  always @(negedge clk_i) begin
    if (hold_off || hold_cycles > 0) begin
      out_ready_i <= 0;
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_tolerance(logic [30:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.tolerance = v;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // offer one ray beat; valid held until accepted, dropped while idling
  task automatic send_ray(ray_box_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    {start_x_i, start_y_i, start_z_i} <= {r.start[0], r.start[1], r.start[2]};
    {delta_x_i, delta_y_i, delta_z_i} <= {r.delta[0], r.delta[1], r.delta[2]};
    {box_min_x_i, box_min_y_i, box_min_z_i} <= {r.bmin[0], r.bmin[1], r.bmin[2]};
    {box_max_x_i, box_max_y_i, box_max_z_i} <= {r.bmax[0], r.bmax[1], r.bmax[2]};
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_ray(r);
    rays_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i <= 0;
  endtask

  task automatic drain();
    drop_valid();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(20 * 65536)) - 10 * 65536;
      default: begin
        case ($urandom_range(4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 0;
          3: return 65536;
          default: return -65536;
        endcase
      end
    endcase
  endfunction

  // mostly well-formed boxes near the ray, some raw noise
  function automatic ray_box_t rand_ray();
    ray_box_t r;
    int mode;
    logic signed [31:0] lo, hi;
    mode = $urandom_range(9) < 7 ? 1 : ($urandom_range(3) == 0 ? 2 : 0);
    for (int a = 0; a < 3; a++) begin
      r.start[a] = rand_coord(mode);
      r.delta[a] = rand_coord(mode);
      lo = rand_coord(mode);
      hi = rand_coord(mode);
      if (mode == 1 && $urandom_range(9) != 0 && lo > hi) begin
        r.bmin[a] = hi; r.bmax[a] = lo;
      end else begin
        r.bmin[a] = lo; r.bmax[a] = hi;
      end
    end
    return r;
  endfunction

  function automatic ray_box_t make_ray(int sx, int sy, int sz, int dx, int dy, int dz,
                                        int lx, int ly, int lz, int ux, int uy, int uz);
    ray_box_t r;
    r.start = '{sx, sy, sz}; r.delta = '{dx, dy, dz};
    r.bmin = '{lx, ly, lz};  r.bmax = '{ux, uy, uz};
    return r;
  endfunction

  task automatic directed_rays();
    localparam int U = 65536;
    localparam int MX = 32'h7FFF_FFFF;
    localparam int MN = 32'h8000_0000;
    // start inside
    send_ray(make_ray(0, 0, 0, U, U, U, -U, -U, -U, U, U, U));
    // enter through each min face and each max face
    send_ray(make_ray(-4*U, 0, 0, 8*U, 0, 0, -U, -U, -U, U, U, U));
    send_ray(make_ray(0, -4*U, 0, 0, 8*U, 0, -U, -U, -U, U, U, U));
    send_ray(make_ray(0, 0, -4*U, 0, 0, 8*U, -U, -U, -U, U, U, U));
    send_ray(make_ray(4*U, 0, 0, -8*U, 0, 0, -U, -U, -U, U, U, U));
    send_ray(make_ray(0, 4*U, 0, 0, -8*U, 0, -U, -U, -U, U, U, U));
    send_ray(make_ray(0, 0, 4*U, 0, 0, -8*U, -U, -U, -U, U, U, U));
    // face wholly in front: early miss, and a late one after an entry
    send_ray(make_ray(-4*U, 0, 0, U, 0, 0, -U, -U, -U, U, U, U));
    send_ray(make_ray(-4*U, 0, 5*U, 8*U, 0, 0, -U, -U, -U, U, U, U));
    // ray misses sideways, staying wholly in front of the max y face
    send_ray(make_ray(-4*U, 3*U, 0, 8*U, -U, 0, -U, -U, -U, U, U, U));
    // inverted box
    send_ray(make_ray(0, 0, 0, U, U, U, U, U, U, -U, -U, -U));
    // extremes: saturating differences and quotients
    send_ray(make_ray(MN, MN, MN, MX, MX, MX, MX, MX, MX, MX, MX, MX));
    send_ray(make_ray(MX, MX, MX, MN, MN, MN, MN, MN, MN, MN, MN, MN));
    send_ray(make_ray(MN, 0, 0, 1, 0, 0, MX, -U, -U, MX, U, U));
    send_ray(make_ray(-U, 0, 0, 1, 0, 0, 0, -U, -U, U, U, U));
    send_ray(make_ray(MX, MN, -1, MN, MX, -1, MN, MN, MN, MX, MX, MX));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0, -1, -1, -1));
    // ray ending exactly on a face
    send_ray(make_ray(-2*U, 0, 0, U, 0, 0, -U, -U, -U, U, U, U));
  endtask

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) send_ray(rand_ray());
  endtask

  initial begin
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0; hold_cycles = 0;
    cycle_count = 0; rays_sent = 0; cfg_writes = 0;
    sb.tolerance = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // reset tolerance of zero first
    directed_rays();
    drain();
    write_tolerance(31'h7FFF_FFFF);
    directed_rays();
    drain();
    write_tolerance(31'd0);
    random_phase(120, 0, 0);
    drain();
    write_tolerance(31'h0000_8000);
    random_phase(80, 82, 0);
    drain();
    write_tolerance(31'($urandom()));
    random_phase(80, 0, 82);
    drain();
    write_tolerance(31'h0001_0000);
    random_phase(80, 9, 9);

    // long receiver hold-off while the sender keeps offering beats
    hold_cycles = 150;
    random_phase(100, 0, 0);
    // sender pauses until every expected result is back
    drain();
    write_tolerance(31'd0);
    random_phase(120, 9, 9);
    drain();

    $display("checked %0d results from %0d rays over %0d tolerance settings",
             sb.checked, rays_sent, cfg_writes + 1);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("ray_box_slab_trace_tb: done, clean");
    else
      $display("ray_box_slab_trace_tb: done, errors");
    $finish;
  end
endmodule
